// ===== hdl/sssr_pkg.sv =====
// Package for the streaming substring replace core.
// Holds shared constants, the queued action type and a small helper function.
// No dependencies.
`default_nettype none

package sssr_pkg;

	// Longest target or replacement, in bytes
	localparam int MAX_PATTERN = 8;
	localparam int BYTE_W      = 8;
	localparam int PAT_W       = MAX_PATTERN * BYTE_W;
	localparam int LEN_W       = 4;
	localparam int POS_W       = 3;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 64;

	// Action queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_TARGET_BYTES  = 2'd0,
		REG_TARGET_LENGTH = 2'd1,
		REG_REPL_BYTES    = 2'd2,
		REG_REPL_LENGTH   = 2'd3
	} reg_idx_t;

	// One queued action: a run of bytes to emit, lowest byte first
	typedef struct packed {
		logic [PAT_W-1:0] data;
		logic [LEN_W-1:0] count;
		logic             last;
	} action_t;

	// Saturate a length at the pattern size
	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] r;
		r = (v > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : v;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/sssr_front.sv =====
// Front end of the substring replace core: config registers, held bytes and
// match classification. Turns each accepted byte into at most one queued action.
// Depends on sssr_pkg.
`default_nettype none

module sssr_front import sssr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// byte stream in
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [BYTE_W-1:0]     s_tdata,
	input  wire logic                  s_tlast,
	// config writes
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// action queue
	input  wire logic                  q_full,
	output logic                       q_push,
	output action_t                    q_entry
);

	// Config registers as written
	logic [PAT_W-1:0] tgt_bytes_q;
	logic [LEN_W-1:0] tgt_len_q;
	logic [PAT_W-1:0] repl_bytes_q;
	logic [LEN_W-1:0] repl_len_q;

	// Pattern latched for the match in progress
	logic [PAT_W-1:0] act_tgt_q;
	logic [LEN_W-1:0] act_tlen_q;
	logic [PAT_W-1:0] act_repl_q;
	logic [LEN_W-1:0] act_rlen_q;

	// Held bytes and fill count
	logic [BYTE_W-1:0] held_q [MAX_PATTERN];
	logic [LEN_W-1:0]  cnt_q;

	logic                  accept;
	logic [PAT_W-1:0]      tgt;
	logic [LEN_W-1:0]      tlen;
	logic [PAT_W-1:0]      repl;
	logic [LEN_W-1:0]      rlen;
	logic [BYTE_W-1:0]     hb [MAX_PATTERN];
	logic [PAT_W-1:0]      h_packed;
	logic [PAT_W-1:0]      h_shifted;
	logic [LEN_W-1:0]      len;
	logic [MAX_PATTERN:0]  pre;
	logic                  match;
	logic [LEN_W-1:0]      ksel;
	logic [LEN_W-1:0]      cnt_nxt;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// Config write decode; out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_bytes_q  <= '0;
			tgt_len_q    <= '0;
			repl_bytes_q <= '0;
			repl_len_q   <= '0;
		end else if (cfg_valid && (cfg_index[CFG_IDX_W-1:2] == '0)) begin
			unique case (reg_idx_t'(cfg_index[1:0]))
				REG_TARGET_BYTES:  tgt_bytes_q  <= cfg_data[PAT_W-1:0];
				REG_TARGET_LENGTH: tgt_len_q    <= cfg_data[LEN_W-1:0];
				REG_REPL_BYTES:    repl_bytes_q <= cfg_data[PAT_W-1:0];
				REG_REPL_LENGTH:   repl_len_q   <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

	// Pattern in effect: live registers when nothing is held
	always_comb begin
		if (cnt_q == '0) begin
			tgt  = tgt_bytes_q;
			tlen = clamp_len(tgt_len_q);
			repl = repl_bytes_q;
			rlen = clamp_len(repl_len_q);
		end else begin
			tgt  = act_tgt_q;
			tlen = act_tlen_q;
			repl = act_repl_q;
			rlen = act_rlen_q;
		end
	end

	// Held run with the new byte appended
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			hb[j] = (LEN_W'(j) == cnt_q) ? s_tdata : held_q[j];
			h_packed[j*BYTE_W +: BYTE_W] = hb[j];
		end
		len = cnt_q + LEN_W'(1);
	end

	// pre[k]: held run from byte k on is a prefix of the target
	always_comb begin
		for (int k = 0; k <= MAX_PATTERN; k++) begin
			pre[k] = 1'b1;
			for (int j = 0; j < MAX_PATTERN; j++) begin
				if ((k + j < MAX_PATTERN) && (k + j < int'(len))) begin
					if (hb[POS_W'(k + j)] != tgt[j*BYTE_W +: BYTE_W])
						pre[k] = 1'b0;
				end
			end
		end
	end

	// Full match, else the fewest bytes to release
	always_comb begin
		match = (tlen != '0) && (len == tlen) && pre[0];
		ksel  = len;
		for (int k = MAX_PATTERN; k >= 0; k--) begin
			if ((k < int'(len)) && ((int'(len) - k) < int'(tlen)) && pre[k])
				ksel = LEN_W'(k);
		end
	end

	// Build the queued action and the remaining held count
	always_comb begin
		h_shifted = h_packed >> {ksel, 3'b000};
		if (match) begin
			q_entry.data  = repl;
			q_entry.count = rlen;
			q_entry.last  = s_tlast;
			cnt_nxt       = '0;
		end else if (s_tlast) begin
			q_entry.data  = h_packed;
			q_entry.count = len;
			q_entry.last  = 1'b1;
			cnt_nxt       = '0;
		end else begin
			q_entry.data  = h_packed;
			q_entry.count = ksel;
			q_entry.last  = 1'b0;
			cnt_nxt       = len - ksel;
		end
		q_push = accept && ((q_entry.count != '0) || q_entry.last);
	end

	// Held state and pattern latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int j = 0; j < MAX_PATTERN; j++)
				held_q[j] <= h_shifted[j*BYTE_W +: BYTE_W];
			if (cnt_q == '0) begin
				act_tgt_q  <= tgt;
				act_tlen_q <= tlen;
				act_repl_q <= repl;
				act_rlen_q <= rlen;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sssr_fifo.sv =====
// Short action queue between the front and back of the replace core.
// Register-based, first-word fall-through head.
// Depends on sssr_pkg.
`default_nettype none

module sssr_fifo import sssr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire action_t push_entry,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output action_t   head
);

	action_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wptr_q;
	logic [FIFO_PTR_W-1:0]  rptr_q;
	logic [FIFO_CNT_W-1:0]  cnt_q;
	logic                   do_pop;

	assign full       = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rptr_q];
	assign do_pop     = pop && head_valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + FIFO_PTR_W'(1);
			if (do_pop)
				rptr_q <= rptr_q + FIFO_PTR_W'(1);
			if (push && !do_pop)
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			else if (!push && do_pop)
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_entry;
	end

endmodule

`default_nettype wire

// ===== hdl/sssr_back.sv =====
// Back end of the replace core: walks each queued action one byte a cycle
// into the output register while that register is free. Depends on sssr_pkg.
`default_nettype none

module sssr_back import sssr_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               head_valid,
	input  wire action_t            head,
	output logic                    pop,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [BYTE_W-1:0]       m_tdata,
	output logic                    m_tuser,
	output logic                    m_tlast
);

	logic [POS_W-1:0]  idx_q;
	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              present_q;
	logic              last_q;
	logic              load;
	logic              done;
	logic [PAT_W-1:0]  sel;

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q;
	assign m_tuser  = present_q;
	assign m_tlast  = last_q;

	// Output register is free when empty or being taken
	assign load = !valid_q || m_tready;
	assign done = (head.count == '0) || (({1'b0, idx_q} + LEN_W'(1)) == head.count);
	assign pop  = load && head_valid && done;
	assign sel  = head.data >> {idx_q, 3'b000};

	// Byte index within the current action
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid)
				idx_q <= done ? '0 : idx_q + POS_W'(1);
		end
	end

	// Output payload; an empty action is a bare end marker
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			byte_q    <= (head.count == '0) ? '0 : sel[BYTE_W-1:0];
			present_q <= (head.count != '0);
			last_q    <= head.last && done;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/stream_substring_replace_core.sv =====
// Streaming substring replace core: front classifier, action queue, emitter.
// Byte stream in on s_*, rewritten stream out on m_*, config writes on cfg_*.
//
// Usage:
//   Input bytes arrive on s_tdata with s_tlast marking the last byte of a
//   string. Every non-overlapping occurrence of the configured target is
//   replaced by the configured replacement. Results leave on m_tdata with
//   m_tuser = 1 for a real byte and m_tuser = 0 for a bare end marker; m_tlast
//   flags the final result of a string.
//   Config writes (cfg_index 0..3: target bytes, target length, replacement
//   bytes, replacement length) are always taken; other indexes are ignored.
//   The pattern in use is latched when a byte arrives with nothing held.
//   A result passes from the classifier through the action queue into the
//   output register. Throughput: one input byte per cycle while each byte
//   yields at most one result; an action of n result bytes occupies the
//   emitter until all n are out, the four-entry action queue absorbs short
//   bursts and s_tready drops when it fills.
//   Reset clears held bytes, the queue, the output register and all config.
//   A stalled m_tready holds the output and backs up into the queue.
`default_nettype none

module stream_substring_replace_core import sssr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input stream; tdata: [7:0] char_byte; tlast: string_end
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [BYTE_W-1:0]     s_tdata,
	input  wire logic                  s_tlast,
	// output stream; tdata: [7:0] out_byte; tuser: [0] byte_present;
	// tlast: last_of_string
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [BYTE_W-1:0]          m_tdata,
	output logic                       m_tuser,
	output logic                       m_tlast,
	// config write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic    q_full;
	logic    q_push;
	action_t q_entry;
	logic    q_pop;
	logic    q_head_valid;
	action_t q_head;

	assign cfg_ready = 1'b1;

	// Classifier
	sssr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	// Action queue
	sssr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// Emitter
	sssr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for stream_substring_replace_core.
// Drives byte strings and pattern registers, predicts the rewritten stream
// in-line and checks every output transaction. Depends on sssr_pkg and the core.

module testbench;
	import sssr_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;

	typedef struct packed {
		logic       eos;
		logic [7:0] data;
	} src_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
	} rewrite_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [BYTE_W-1:0]     m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Source bytes waiting to go in, rewritten bytes waiting to come out
	src_item_t source_q[$];
	rewrite_t  rewritten_q[$];

	// Shadow of the pattern registers and of the pattern in use
	logic [63:0] tgt_reg, rep_reg, tgt_use, rep_use;
	logic [3:0]  tlen_reg, rlen_reg;
	int          tlen_use, rlen_use;
	logic [7:0]  held[MAX_PATTERN];
	int          held_n;
	int          step_results;

	int mismatches = 0;
	int quiet_cycles = 0;
	int src_gap = 0;
	int snk_gap = 0;
	bit calm = 1'b0;

	stream_substring_replace_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	// Register write as the core sees it; unknown indexes change nothing
	task automatic shadow_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		case (idx)
			CFG_IDX_W'(REG_TARGET_BYTES):  tgt_reg = data;
			CFG_IDX_W'(REG_TARGET_LENGTH): tlen_reg = data[3:0];
			CFG_IDX_W'(REG_REPL_BYTES):    rep_reg = data;
			CFG_IDX_W'(REG_REPL_LENGTH):   rlen_reg = data[3:0];
			default: ;
		endcase
	endtask

	// One rewritten byte; a step never yields more than MAX_PATTERN
	task automatic push_rewrite(input logic [7:0] b, input logic present);
		rewrite_t r;
		r.data = b;
		r.present = present;
		r.last = 1'b0;
		if (step_results < MAX_PATTERN) begin
			rewritten_q.push_back(r);
			step_results++;
		end
	endtask

	function automatic bit held_matches_target();
		for (int i = 0; i < held_n; i++)
			if (held[i] != tgt_use[8*i +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	// Find-and-replace step for one accepted source byte
	task automatic rewrite_step(input logic [7:0] b, input logic eos);
		rewrite_t r;
		bit pfx;
		step_results = 0;
		// pattern only changes while nothing is held
		if (held_n == 0) begin
			tgt_use = tgt_reg;
			rep_use = rep_reg;
			tlen_use = (tlen_reg > MAX_PATTERN) ? MAX_PATTERN : int'(tlen_reg);
			rlen_use = (rlen_reg > MAX_PATTERN) ? MAX_PATTERN : int'(rlen_reg);
		end
		if (held_n < MAX_PATTERN) begin
			held[held_n] = b;
			held_n++;
		end
		// release oldest bytes until the rest is a target prefix or a full match
		while (held_n > 0) begin
			pfx = held_matches_target();
			if (tlen_use > 0 && held_n == tlen_use && pfx) begin
				for (int i = 0; i < rlen_use; i++)
					push_rewrite(rep_use[8*i +: 8], 1'b1);
				held_n = 0;
			end else if (tlen_use > 0 && held_n < tlen_use && pfx) begin
				break;
			end else begin
				push_rewrite(held[0], 1'b1);
				for (int i = 0; i < MAX_PATTERN - 1; i++)
					held[i] = held[i+1];
				held_n--;
			end
		end
		// end of string: flush, bare marker if nothing came out
		if (eos) begin
			for (int i = 0; i < held_n; i++)
				push_rewrite(held[i], 1'b1);
			held_n = 0;
			if (step_results == 0)
				push_rewrite(8'h00, 1'b0);
			r = rewritten_q[rewritten_q.size()-1];
			r.last = 1'b1;
			rewritten_q[rewritten_q.size()-1] = r;
		end
	endtask

	// Source side driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			src_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				rewrite_step(s_tdata, s_tlast);
				void'(source_q.pop_front());
			end
			// keep a pending transaction on the bus until it is taken
			if (!(s_tvalid && !s_tready)) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (source_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					src_gap = $urandom_range(0, 2);
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= source_q[0].data;
					s_tlast <= source_q[0].eos;
				end
			end
		end
	end

	// Output side: random backpressure and field checks
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (rewritten_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result %02h user %b last %b",
						m_tdata, m_tuser, m_tlast));
				end else begin
					rewrite_t w;
					w = rewritten_q.pop_front();
					if (m_tdata !== w.data)
						report_mismatch($sformatf("out_byte got %02h want %02h", m_tdata, w.data));
					if (m_tuser !== w.present)
						report_mismatch($sformatf("byte_present got %b want %b",
							m_tuser, w.present));
					if (m_tlast !== w.last)
						report_mismatch($sformatf("last_of_string got %b want %b",
							m_tlast, w.last));
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				snk_gap = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Ends the run when nothing moves for too long
	initial begin : watchdog
		@(posedge arst_n);
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		shadow_write(idx, data);
		cfg_valid <= 1'b0;
	endtask

	// Lengths go out with random upper bits, which the core must ignore
	task automatic load_pattern(input logic [63:0] tgt, input int tl,
			input logic [63:0] rep, input int rl);
		logic [63:0] w;
		write_reg(CFG_IDX_W'(REG_TARGET_BYTES), tgt);
		w = {$urandom, $urandom};
		w[3:0] = 4'(tl);
		write_reg(CFG_IDX_W'(REG_TARGET_LENGTH), w);
		write_reg(CFG_IDX_W'(REG_REPL_BYTES), rep);
		w = {$urandom, $urandom};
		w[3:0] = 4'(rl);
		write_reg(CFG_IDX_W'(REG_REPL_LENGTH), w);
	endtask

	task automatic send(input logic [7:0] b, input logic eos);
		src_item_t it;
		it.data = b;
		it.eos = eos;
		source_q.push_back(it);
	endtask

	// Wait until every byte is in and every result is out, then let the core settle
	task automatic drain();
		do @(negedge clk); while (source_q.size() != 0 || rewritten_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_letter();
		return 8'h61 + 8'($urandom_range(0, 2));
	endfunction

	// Random strings built mostly from target pieces, the rest noise
	task automatic random_phase(input int budget, input bit narrow);
		logic [63:0] tgt;
		int tl, eff, cut, k;
		tgt = {$urandom, $urandom};
		if (narrow)
			for (int i = 0; i < MAX_PATTERN; i++)
				tgt[8*i +: 8] = pick_letter();
		case ($urandom_range(0, 9))
			0: tl = 0;
			9: tl = $urandom_range(9, 15);
			8: tl = MAX_PATTERN;
			default: tl = $urandom_range(1, 4);
		endcase
		load_pattern(tgt, tl, {$urandom, $urandom}, $urandom_range(0, 15));
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(4, 255)), {$urandom, $urandom});
		eff = (tl > MAX_PATTERN) ? MAX_PATTERN : tl;
		k = 0;
		while (k < budget) begin
			if (eff > 0 && $urandom_range(0, 2) != 0) begin
				cut = ($urandom_range(0, 1) == 0) ? eff : $urandom_range(1, eff);
				for (int i = 0; i < cut; i++)
					send(tgt[8*i +: 8], $urandom_range(0, 9) == 0);
				k += cut;
			end else begin
				send(narrow ? pick_letter() : 8'($urandom_range(0, 255)),
					$urandom_range(0, 7) == 0);
				k++;
			end
		end
		// now and then leave a string open across the next register update
		if ($urandom_range(0, 3) != 0) begin
			send(narrow ? pick_letter() : 8'($urandom_range(0, 255)), 1'b1);
		end
		drain();
	endtask

	// Stimulus sequence
	initial begin
		tgt_reg = '0;
		rep_reg = '0;
		tlen_reg = '0;
		rlen_reg = '0;
		tgt_use = '0;
		rep_use = '0;
		tlen_use = 0;
		rlen_use = 0;
		held_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty target passes bytes through; unknown indexes are ignored
		write_reg(8'hFF, {$urandom, $urandom});
		write_reg(8'h04, {$urandom, $urandom});
		send(8'h00, 1'b0);
		send(8'hFF, 1'b0);
		send(8'h5A, 1'b1);
		send(8'h80, 1'b1);
		drain();

		// "aab" -> "XY": match restarts at the mismatching byte, end flushes
		load_pattern(64'h626161, 3, 64'h5958, 2);
		send(8'h61, 1'b0);
		send(8'h61, 1'b0);
		send(8'h61, 1'b0);
		send(8'h62, 1'b0);
		send(8'h61, 1'b0);
		send(8'h61, 1'b1);
		drain();

		// both lengths above the pattern size saturate to eight bytes
		load_pattern(64'h00FF_7E81_A55A_FF00, 15, 64'hFF08_0706_0504_0300, 12);
		send(8'h00, 1'b0);
		send(8'hFF, 1'b0);
		send(8'h5A, 1'b0);
		send(8'hA5, 1'b0);
		send(8'h81, 1'b0);
		send(8'h7E, 1'b0);
		send(8'hFF, 1'b0);
		send(8'h00, 1'b1);
		drain();

		// empty replacement deletes; end with nothing left gives a bare marker
		load_pattern(64'h0, 1, 64'h0, 0);
		send(8'h00, 1'b1);
		send(8'h11, 1'b0);
		send(8'h00, 1'b1);
		drain();

		// target rewritten while a partial match is held: old pattern stays
		load_pattern(64'h6261, 2, 64'h5A, 1);
		send(8'h61, 1'b0);
		drain();
		write_reg(CFG_IDX_W'(REG_TARGET_BYTES), 64'h6463);
		send(8'h62, 1'b0);
		send(8'h63, 1'b0);
		send(8'h64, 1'b1);
		drain();

		// random phases; the last ones run without idling
		for (int ph = 0; ph < 8; ph++) begin
			if (ph >= 6)
				calm = 1'b1;
			random_phase(28, ph % 2 == 0);
		end

		// close any string still open and let the last results out
		send(8'h00, 1'b1);
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/sssr_pkg.sv
hdl/sssr_front.sv
hdl/sssr_fifo.sv
hdl/sssr_back.sv
hdl/stream_substring_replace_core.sv
tb/testbench.sv
